[src/rcf_pkg.sv]
// Package for the radix converter with fraction: FSM state type and register indexes.
// No dependencies; used by radix_converter_with_fraction_core.
`default_nettype none
package rcf_pkg;
  typedef enum logic [2:0] {
    StIdle,
    StIntDiv,
    StIntEmit,
    StFracRead,
    StFracDiv,
    StFracEmit
  } state_e;

  localparam logic [0:0] RegSourceBase = 1'b0;
  localparam logic [0:0] RegTargetBase = 1'b1;
endpackage
`default_nettype wire

[src/radix_converter_with_fraction_core.sv]
// Radix converter with fraction: top level and the only module.
// Depends on rcf_pkg for the state type and register indexes.
`default_nettype none
//
//  Channel   Direction  Handshake                  Payload
//  ------    ---------  -------------------------  -------------------------------------------
//  in        in         in_valid_i/in_ready_o      digit_in_i, is_fraction_i, is_last_i
//  out       out        out_valid_o/out_ready_i    digit_out_o, frac_digit_o, overflow_o,
//                                                  last_out_o
//  cfg       in         cfg_we_i                   cfg_idx_i, cfg_data_i
//
// A digit that is not last is taken while the block is idle: integer digits
// update the Horner accumulator, fraction digits are written to the fraction
// memory. On the last digit the block converts. Each integer output digit is
// produced by the bit-serial divider and then stored; after an address step
// the stored digits are emitted, most significant first. Each stored fraction
// digit is read from memory and divided by the source base in the bit-serial
// divider; once the fraction memory is found empty, OUT_FRAC_DIGITS fraction
// digits are emitted. Reset clears the control state; the memories need no
// clearing. A stalled output simply holds the emitter; no request is lost.
module radix_converter_with_fraction_core
  import rcf_pkg::*;
#(
  parameter int INT_BITS        = 32,
  parameter int MAX_FRAC_IN     = 64,
  parameter int OUT_FRAC_DIGITS = 20,
  parameter int FRAC_BITS       = 48
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  input  wire logic [3:0] digit_in_i,
  input  wire logic       is_fraction_i,
  input  wire logic       is_last_i,
  output logic            out_valid_o,
  input  wire logic       out_ready_i,
  output logic [3:0]      digit_out_o,
  output logic            frac_digit_o,
  output logic            overflow_o,
  output logic            last_out_o,
  input  wire logic       cfg_we_i,
  input  wire logic       cfg_idx_i,
  input  wire logic [4:0] cfg_data_i
);
  localparam int FcW    = $clog2(MAX_FRAC_IN + 1);
  localparam int FaW    = (MAX_FRAC_IN > 1) ? $clog2(MAX_FRAC_IN) : 1;
  localparam int IcW    = $clog2(INT_BITS + 1);
  localparam int IaW    = $clog2(INT_BITS);
  localparam int ObW    = $clog2(INT_BITS);
  localparam int OfW    = $clog2(OUT_FRAC_DIGITS + 1);
  localparam int DivN   = FRAC_BITS + 4;
  localparam int DivMax = (DivN > INT_BITS) ? DivN : INT_BITS;
  localparam int DcW    = $clog2(DivMax + 1);

  logic [4:0] src_base_q, tgt_base_q;
  logic [4:0] sb, tb;

  always_comb begin
    sb = (src_base_q < 5'd2) ? 5'd2 : (src_base_q > 5'd16) ? 5'd16 : src_base_q;
    tb = (tgt_base_q < 5'd2) ? 5'd2 : (tgt_base_q > 5'd16) ? 5'd16 : tgt_base_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_base_q <= 5'd10;
      tgt_base_q <= 5'd2;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == RegSourceBase) src_base_q <= cfg_data_i;
      if (cfg_idx_i == RegTargetBase) tgt_base_q <= cfg_data_i;
    end
  end

  // Memories: fraction digits in, integer digits out.
  logic [3:0] frac_mem [MAX_FRAC_IN];
  logic [3:0] int_mem  [INT_BITS];
  logic [3:0] frac_rd_q, int_rd_q;
  logic       frac_we, int_we;
  logic [FaW-1:0] frac_wa, frac_ra;
  logic [IaW-1:0] int_wa, int_ra;
  logic [3:0] frac_wd, int_wd;

  always_ff @(posedge clk_i) begin
    if (frac_we) frac_mem[frac_wa] <= frac_wd;
    frac_rd_q <= frac_mem[frac_ra];
    if (int_we) int_mem[int_wa] <= int_wd;
    int_rd_q <= int_mem[int_ra];
  end

  state_e state_q, state_d;
  logic [INT_BITS-1:0] ival_q, ival_d;
  logic [FcW-1:0] fcnt_q, fcnt_d;
  logic infrac_q, infrac_d, sat_q, sat_d;
  // Shared long-division remainder; fq holds the fraction quotient.
  logic [4:0] rem_q, rem_d;
  logic [IcW-1:0] ndig_q, ndig_d;
  logic [DcW-1:0] cnt_q, cnt_d;
  logic [FRAC_BITS+3:0] fq_q, fq_d;
  logic [FRAC_BITS-1:0] f_q, f_d;
  logic [OfW-1:0] ofc_q, ofc_d;
  logic out_valid_q, out_valid_d;
  logic [3:0] dout_q, dout_d;
  logic fr_q, fr_d, last_q, last_d, ovf_q, ovf_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      ival_q      <= '0;
      fcnt_q      <= '0;
      infrac_q    <= 1'b0;
      sat_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      ival_q      <= ival_d;
      fcnt_q      <= fcnt_d;
      infrac_q    <= infrac_d;
      sat_q       <= sat_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    ndig_q <= ndig_d;
    cnt_q  <= cnt_d;
    fq_q   <= fq_d;
    f_q    <= f_d;
    ofc_q  <= ofc_d;
    dout_q <= dout_d;
    fr_q   <= fr_d;
    last_q <= last_d;
    ovf_q  <= ovf_d;
  end

  logic [3:0] dclamp;
  logic fr_now;
  logic [INT_BITS+4:0] mac;
  logic [5:0] rsh;
  logic [FRAC_BITS+4:0] fprod;
  logic out_free;

  assign in_ready_o   = (state_q == StIdle);
  assign out_valid_o  = out_valid_q;
  assign digit_out_o  = dout_q;
  assign frac_digit_o = fr_q;
  assign overflow_o   = ovf_q;
  assign last_out_o   = last_q;

  always_comb begin
    state_d = state_q;
    ival_d = ival_q; fcnt_d = fcnt_q; infrac_d = infrac_q; sat_d = sat_q;
    rem_d = rem_q; ndig_d = ndig_q; cnt_d = cnt_q; fq_d = fq_q; f_d = f_q;
    ofc_d = ofc_q; dout_d = dout_q; fr_d = fr_q; last_d = last_q; ovf_d = ovf_q;
    out_free = !out_valid_q || out_ready_i;
    out_valid_d = out_valid_q && !out_ready_i;
    frac_we = 1'b0; frac_wa = fcnt_q[FaW-1:0]; frac_wd = '0;
    frac_ra = '0;
    int_we = 1'b0; int_wa = ndig_q[IaW-1:0]; int_wd = rem_q[3:0];
    int_ra = '0;
    dclamp = ({1'b0, digit_in_i} >= sb) ? 4'(sb - 5'd1) : digit_in_i;
    fr_now = infrac_q | is_fraction_i;
    mac = {5'd0, ival_q} * {{INT_BITS{1'b0}}, sb} + {{(INT_BITS+1){1'b0}}, dclamp};
    rsh = {rem_q, 1'b0};
    fprod = {5'd0, f_q} * {{FRAC_BITS{1'b0}}, tb};
    case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          infrac_d = fr_now;
          if (fr_now) begin
            if (fcnt_q < FcW'(MAX_FRAC_IN)) begin
              frac_we = 1'b1;
              frac_wd = dclamp;
              fcnt_d  = fcnt_q + 1'b1;
            end
          end else if (mac[INT_BITS+4:INT_BITS] != '0) begin
            ival_d = '1;
            sat_d  = 1'b1;
          end else begin
            ival_d = mac[INT_BITS-1:0];
          end
          if (is_last_i) begin
            // Start integer division of the accumulator.
            rem_d  = '0;
            cnt_d  = '0;
            ndig_d = '0;
            state_d = StIntDiv;
          end
        end
      end
      StIntDiv: begin
        // One quotient bit per cycle; ival holds the shifting dividend.
        rsh = {1'b0, rem_q[3:0], ival_q[INT_BITS-1]};
        if (rsh >= {1'b0, tb}) begin
          rem_d  = 5'(rsh - {1'b0, tb});
          ival_d = {ival_q[INT_BITS-2:0], 1'b1};
        end else begin
          rem_d  = rsh[4:0];
          ival_d = {ival_q[INT_BITS-2:0], 1'b0};
        end
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == DcW'(INT_BITS - 1)) begin
          cnt_d = '0;
          state_d = StIntEmit;
        end
      end
      StIntEmit: begin
        // rem is the digit, ival the quotient.
        if (cnt_q == '0) begin
          int_we = 1'b1;
          ndig_d = ndig_q + 1'b1;
          if (ival_q != '0 && ndig_q != IcW'(INT_BITS - 1)) begin
            rem_d = '0;
            state_d = StIntDiv;
          end else begin
            cnt_d = DcW'(1);
          end
          int_ra = ObW'(ndig_q);
        end else begin
          // Emit digits from ndig-1 down; the memory read is registered.
          if (cnt_q == DcW'(1)) begin
            int_ra = ObW'(ndig_q - 1'b1);
            cnt_d = DcW'(2);
          end else if (out_free) begin
            out_valid_d = 1'b1;
            dout_d = int_rd_q;
            fr_d = 1'b0;
            last_d = 1'b0;
            ovf_d = sat_q;
            ndig_d = ndig_q - 1'b1;
            if (ndig_q == IcW'(1)) begin
              f_d = '0;
              state_d = StFracRead;
            end else begin
              int_ra = ObW'(ndig_q - 2'd2);
            end
          end else begin
            int_ra = ObW'(ndig_q - 1'b1);
          end
        end
      end
      StFracRead: begin
        if (fcnt_q == '0) begin
          ofc_d = '0;
          state_d = StFracEmit;
        end else begin
          frac_ra = FaW'(fcnt_q - 1'b1);
          cnt_d = '0;
          rem_d = '0;
          state_d = StFracDiv;
        end
      end
      StFracDiv: begin
        // Dividend is {digit, f}; shift one bit per cycle.
        rsh = {1'b0, rem_q[3:0], (cnt_q == '0) ? frac_rd_q[3] : fq_q[FRAC_BITS+3]};
        if (cnt_q != '0) fq_d = {fq_q[FRAC_BITS+2:0], 1'b0};
        else fq_d = {frac_rd_q[2:0], f_q, 1'b0};
        if (rsh >= {1'b0, sb}) begin
          rem_d = 5'(rsh - {1'b0, sb});
          fq_d[0] = 1'b1;
        end else begin
          rem_d = rsh[4:0];
        end
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == DcW'(DivN - 1)) begin
          f_d = fq_d[FRAC_BITS-1:0];
          fcnt_d = fcnt_q - 1'b1;
          state_d = StFracRead;
        end
      end
      StFracEmit: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          dout_d = fprod[FRAC_BITS+3:FRAC_BITS];
          f_d = fprod[FRAC_BITS-1:0];
          fr_d = 1'b1;
          ovf_d = sat_q;
          last_d = (ofc_q == OfW'(OUT_FRAC_DIGITS - 1));
          ofc_d = ofc_q + 1'b1;
          if (ofc_q == OfW'(OUT_FRAC_DIGITS - 1)) begin
            ival_d = '0; fcnt_d = '0; infrac_d = 1'b0; sat_d = 1'b0;
            state_d = StIdle;
          end
        end
      end
      default: state_d = StIdle;
    endcase
  end

  // The overflow flag travels with each output register load, so the next
  // number may clear its accumulation state while the last digit still waits.
  logic unused_ok;
  assign unused_ok = ^{fprod[FRAC_BITS+4]};
endmodule
`default_nettype wire

[tb/tb.sv]
// Testbench for radix_converter_with_fraction_core: self-checking digit stream tests.
// Depends on rcf_pkg and the core RTL; holds its own conversion predictor.
`default_nettype none
module tb;
  import rcf_pkg::*;

  localparam int IntW     = 32;
  localparam int FracMax  = 64;
  localparam int FracOut  = 20;
  localparam int FracW    = 48;
  localparam int IdleLimit = 20000;

  typedef struct packed {
    logic [3:0] digit;
    logic       frac;
    logic       ovf;
    logic       last;
  } out_digit_t;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       in_valid_i = 1'b0;
  logic       in_ready_o;
  logic [3:0] digit_in_i = '0;
  logic       is_fraction_i = 1'b0;
  logic       is_last_i = 1'b0;
  logic       out_valid_o;
  logic       out_ready_i = 1'b0;
  logic [3:0] digit_out_o;
  logic       frac_digit_o;
  logic       overflow_o;
  logic       last_out_o;
  logic       cfg_we_i = 1'b0;
  logic       cfg_idx_i = 1'b0;
  logic [4:0] cfg_data_i = '0;

  radix_converter_with_fraction_core dut (.*);

  initial forever #5 clk_i = ~clk_i;

  // Predictor state for the number currently being received.
  logic [4:0]  src_reg = 5'd10;
  logic [4:0]  dst_reg = 5'd2;
  logic [63:0] acc_int;
  logic [3:0]  frac_digits [FracMax];
  int          n_frac;
  bit          in_frac;
  bit          sat;
  out_digit_t  expected_digits [$];
  int          failures = 0;
  int          idle_cycles = 0;
  bit          stall_on = 1'b0;

  function automatic logic [4:0] clamp_radix(logic [4:0] b);
    if (b < 2) return 5'd2;
    if (b > 16) return 5'd16;
    return b;
  endfunction

  // Apply one input digit to the predictor and queue the digits it produces.
  task automatic predict_digit(logic [3:0] d, logic fr, logic lst);
    logic [4:0]   sb;
    logic [4:0]   tgt;
    logic [3:0]   dd;
    logic [63:0]  v;
    logic [3:0]   rev [$];
    logic [FracW-1:0] f;
    logic [FracW+4:0] num;
    logic [FracW+4:0] prod;
    out_digit_t   o;
    sb = clamp_radix(src_reg);
    dd = (d >= sb) ? 4'(sb - 1) : d;
    if (fr) in_frac = 1'b1;
    if (in_frac) begin
      if (n_frac < FracMax) begin
        frac_digits[n_frac] = dd;
        n_frac++;
      end
    end else if (acc_int > (64'hFFFF_FFFF - dd) / sb) begin
      acc_int = 64'hFFFF_FFFF;
      sat = 1'b1;
    end else begin
      acc_int = acc_int * sb + dd;
    end
    if (!lst) return;
    tgt = clamp_radix(dst_reg);
    v = acc_int;
    do begin
      rev.push_front(4'(v % tgt));
      v = v / tgt;
    end while (v != 0);
    foreach (rev[i]) begin
      o = '{rev[i], 1'b0, sat, 1'b0};
      expected_digits.push_back(o);
    end
    f = '0;
    for (int j = n_frac - 1; j >= 0; j--) begin
      num = {frac_digits[j], f};
      f = FracW'(num / sb);
    end
    for (int i = 0; i < FracOut; i++) begin
      prod = {5'd0, f} * tgt;
      o = '{4'(prod >> FracW), 1'b1, sat, i == FracOut - 1};
      expected_digits.push_back(o);
      f = prod[FracW-1:0];
    end
    acc_int = '0;
    n_frac = 0;
    in_frac = 1'b0;
    sat = 1'b0;
  endtask

  // Send one digit request, then hold valid until it is accepted.
  task automatic send_digit(logic [3:0] d, logic fr, logic lst);
    in_valid_i    <= 1'b1;
    digit_in_i    <= d;
    is_fraction_i <= fr;
    is_last_i     <= lst;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    predict_digit(d, fr, lst);
    // Bursty sender: sometimes drop valid for a random gap.
    if ($urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
    end
  endtask

  task automatic send_number(int n_int, int n_fr, logic [3:0] maxd);
    for (int i = 0; i < n_int; i++)
      send_digit(4'($urandom_range(0, maxd)), 1'b0, n_fr == 0 && i == n_int - 1);
    for (int i = 0; i < n_fr; i++)
      send_digit(4'($urandom_range(0, maxd)), 1'b1, i == n_fr - 1);
    if (n_int == 0 && n_fr == 0) send_digit(4'($urandom_range(0, maxd)), 1'b0, 1'b1);
  endtask

  // Registers are only written once all expected digits have drained.
  task automatic write_reg(logic idx, logic [4:0] val);
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (expected_digits.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == RegSourceBase) src_reg = val;
    else dst_reg = val;
  endtask

  task automatic test_extremes();
    send_digit(4'd0, 1'b0, 1'b1);                 // zero integer gives a single 0
    send_digit(4'd15, 1'b0, 1'b0);                // digit clamped to base minus one
    send_digit(4'd9, 1'b1, 1'b0);
    send_digit(4'd3, 1'b0, 1'b1);                 // integer flag after a fraction digit
    send_digit(4'd5, 1'b1, 1'b1);                 // no integer digits at all
    for (int i = 0; i < 12; i++) send_digit(4'd9, 1'b0, 1'b0);
    send_digit(4'd9, 1'b0, 1'b1);                 // saturates the accumulator
  endtask

  task automatic test_long_fraction();
    for (int i = 0; i < FracMax + 4; i++)         // digits past the store are dropped
      send_digit(4'($urandom_range(0, 15)), 1'b1, i == FracMax + 3);
  endtask

  task automatic test_base_extremes();
    write_reg(RegSourceBase, 5'd16);
    write_reg(RegTargetBase, 5'd16);
    send_number(8, 3, 4'd15);
    write_reg(RegSourceBase, 5'd2);
    write_reg(RegTargetBase, 5'd10);
    send_number(33, 4, 4'd1);
    write_reg(RegSourceBase, 5'd0);               // out-of-range bases are clamped
    write_reg(RegTargetBase, 5'd31);
    send_number(4, 2, 4'd15);
    write_reg(RegSourceBase, 5'd31);
    write_reg(RegTargetBase, 5'd1);
    send_number(3, 2, 4'd15);
  endtask

  task automatic test_random_numbers();
    int sent;
    sent = 0;
    while (sent < 225) begin
      int ni;
      int nf;
      if ($urandom_range(0, 7) == 0) begin
        write_reg(RegSourceBase, 5'($urandom_range(0, 31)));
        write_reg(RegTargetBase, 5'($urandom_range(0, 31)));
      end
      ni = $urandom_range(0, 10);
      nf = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 70) : $urandom_range(0, 6);
      send_number(ni, nf, 4'd15);
      sent += (ni + nf == 0) ? 1 : ni + nf;
    end
  endtask

  // Receiver stall pattern: alternates long ready runs with random stalls.
  always @(posedge clk_i) begin
    if ($urandom_range(0, 15) == 0) stall_on <= ~stall_on;
    out_ready_i <= stall_on ? ($urandom_range(0, 3) == 0) : 1'b1;
  end

  // Compare each accepted output digit with the oldest expectation.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_digits.size() == 0) begin
        $error("digit out with nothing expected");
        failures++;
      end else begin
        out_digit_t e;
        e = expected_digits.pop_front();
        if (digit_out_o !== e.digit) begin
          $error("digit_out exp %0d got %0d", e.digit, digit_out_o); failures++;
        end
        if (frac_digit_o !== e.frac) begin
          $error("frac_digit exp %0d got %0d", e.frac, frac_digit_o); failures++;
        end
        if (overflow_o !== e.ovf) begin
          $error("overflow exp %0d got %0d", e.ovf, overflow_o); failures++;
        end
        if (last_out_o !== e.last) begin
          $error("last_out exp %0d got %0d", e.last, last_out_o); failures++;
        end
      end
    end
  end

  // Watchdog: the idle limit is generous beside the longest conversions.
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > IdleLimit) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    acc_int = '0;
    n_frac = 0;
    in_frac = 1'b0;
    sat = 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_extremes();
    test_long_fraction();
    test_base_extremes();
    write_reg(RegSourceBase, 5'd10);
    write_reg(RegTargetBase, 5'd2);
    test_random_numbers();
    in_valid_i <= 1'b0;
    while (expected_digits.size() != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
    if (failures == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end
endmodule
`default_nettype wire
